// File: design/cmsc_pkg.sv
// ----------------------------------------------------------------------------
// cmsc_pkg
// Types and state codes shared by the conveyor metal-sort controller.
// ----------------------------------------------------------------------------
package cmsc_pkg;

	localparam int PHASE_W = 4;

	localparam logic [PHASE_W-1:0] PH_START     = 4'd0;
	localparam logic [PHASE_W-1:0] PH_STANDBY   = 4'd1;
	localparam logic [PHASE_W-1:0] PH_READY     = 4'd2;
	localparam logic [PHASE_W-1:0] PH_TRANSPORT = 4'd3;
	localparam logic [PHASE_W-1:0] PH_DETECT    = 4'd4;
	localparam logic [PHASE_W-1:0] PH_NONMETAL  = 4'd5;
	localparam logic [PHASE_W-1:0] PH_END       = 4'd6;
	localparam logic [PHASE_W-1:0] PH_METAL     = 4'd7;
	localparam logic [PHASE_W-1:0] PH_SLIDE     = 4'd8;
	localparam logic [PHASE_W-1:0] PH_ERROR     = 4'd9;

	typedef struct packed {
		logic start_released;
		logic item_at_begin;
		logic item_at_height;
		logic item_at_metal;
		logic metal_found;
		logic item_at_end;
		logic item_passed_slide;
		logic seconds_odd;
	} sample_t;

	typedef struct packed {
		logic               drive_right;
		logic               lamp_green;
		logic               lamp_red;
		logic               lamp_yellow;
		logic               start_led;
		logic               gate_open;
		logic [PHASE_W-1:0] phase;
	} result_t;

endpackage

// File: design/cmsc_step.sv
// ----------------------------------------------------------------------------
// cmsc_step
// One controller tick: next phase from the sensor sample, then the sticky
// output update for the new phase.
// ----------------------------------------------------------------------------
module cmsc_step import cmsc_pkg::*; (
	input  result_t cur,
	input  sample_t smp,
	output result_t nxt
);

	logic [PHASE_W-1:0] ph_n;

	// later checks override earlier ones; error checks come last
	always_comb begin
		ph_n = cur.phase;
		case (cur.phase)
			PH_START: begin
				ph_n = PH_STANDBY;
			end
			PH_STANDBY: begin
				if (smp.start_released) ph_n = PH_READY;
			end
			PH_READY: begin
				if (smp.start_released) ph_n = PH_STANDBY;
				if (smp.item_at_begin && !smp.item_at_end) ph_n = PH_TRANSPORT;
				if (smp.item_at_height || smp.item_at_metal) ph_n = PH_ERROR;
			end
			PH_TRANSPORT: begin
				if (smp.item_at_metal) ph_n = PH_DETECT;
				if (smp.item_at_end) ph_n = PH_ERROR;
			end
			PH_DETECT: begin
				ph_n = smp.metal_found ? PH_METAL : PH_NONMETAL;
			end
			PH_NONMETAL: begin
				if (smp.item_at_end) ph_n = PH_END;
				if (smp.item_at_begin || smp.item_at_height) ph_n = PH_ERROR;
			end
			PH_END: begin
				if (smp.start_released) ph_n = PH_STANDBY;
				if (!smp.item_at_end) ph_n = PH_READY;
				if (smp.item_at_metal || smp.item_at_height) ph_n = PH_ERROR;
			end
			PH_METAL: begin
				if (smp.item_passed_slide) ph_n = PH_SLIDE;
				if (smp.item_at_begin || smp.item_at_height) ph_n = PH_ERROR;
			end
			PH_SLIDE: begin
				if (smp.start_released) ph_n = PH_STANDBY;
				if (smp.item_at_begin) ph_n = PH_TRANSPORT;
				if (smp.item_at_end || smp.item_at_height) ph_n = PH_ERROR;
			end
			PH_ERROR: begin
				if (smp.start_released) ph_n = PH_STANDBY;
			end
			default: begin
				ph_n = PH_START;
			end
		endcase
	end

	// hold any output the new phase does not name
	always_comb begin
		nxt       = cur;
		nxt.phase = ph_n;
		case (ph_n)
			PH_START, PH_STANDBY: begin
				nxt.drive_right = 1'b0;
				nxt.lamp_green  = 1'b0;
				nxt.lamp_red    = 1'b0;
				nxt.lamp_yellow = 1'b0;
				nxt.start_led   = 1'b1;
			end
			PH_READY, PH_SLIDE: begin
				nxt.drive_right = 1'b0;
				nxt.lamp_green  = 1'b1;
				nxt.lamp_red    = 1'b0;
				nxt.lamp_yellow = 1'b0;
				nxt.start_led   = 1'b1;
			end
			PH_TRANSPORT: begin
				nxt.drive_right = 1'b1;
				nxt.lamp_green  = 1'b1;
				nxt.lamp_red    = 1'b0;
				nxt.lamp_yellow = 1'b0;
				nxt.start_led   = 1'b0;
			end
			PH_DETECT: begin
				nxt.drive_right = 1'b0;
				nxt.lamp_green  = 1'b1;
				nxt.lamp_red    = 1'b0;
				nxt.lamp_yellow = 1'b0;
			end
			PH_NONMETAL: begin
				nxt.drive_right = 1'b1;
				nxt.lamp_green  = 1'b1;
				nxt.lamp_red    = 1'b0;
				nxt.lamp_yellow = 1'b0;
				nxt.start_led   = 1'b0;
				nxt.gate_open   = 1'b1;
			end
			PH_END: begin
				nxt.drive_right = 1'b0;
				nxt.lamp_green  = smp.seconds_odd;
				nxt.lamp_red    = 1'b0;
				nxt.lamp_yellow = 1'b0;
				nxt.start_led   = 1'b1;
				nxt.gate_open   = 1'b0;
			end
			PH_METAL: begin
				nxt.drive_right = 1'b1;
				nxt.lamp_green  = 1'b0;
				nxt.lamp_red    = 1'b0;
				nxt.lamp_yellow = 1'b1;
			end
			PH_ERROR: begin
				nxt.drive_right = 1'b0;
				nxt.lamp_green  = 1'b0;
				nxt.lamp_red    = smp.seconds_odd;
				nxt.lamp_yellow = 1'b0;
				nxt.start_led   = 1'b1;
				nxt.gate_open   = 1'b0;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

// File: design/conveyor_metal_sort_controller_top.sv
// ----------------------------------------------------------------------------
// conveyor_metal_sort_controller_top
// Sorter state machine for a conveyor with metal detection and reject slide.
// ----------------------------------------------------------------------------
// Usage:
//   The sample channel (sample_valid / sample_stall / sample) carries one
//   sensor snapshot per control tick. The result channel (result_valid /
//   result_stall / result) returns one item per sample: lamp, motor, gate
//   and start LED settings plus the phase reached.
//   Path: an accepted sample is registered in the input register, then
//   evaluated against the controller state, and its result is written to
//   the result register, which drives result directly.
//   Throughput: one sample per cycle unless stalled; the controller state and
//   the result register are written together by the single evaluation stage.
//   Reset: phase returns to Start and every output bit clears; no result is
//   pending.
//   Stall: while result_stall holds a result, the evaluation stage waits and
//   the held result does not change; one further sample is taken into the
//   input register before sample_stall rises.
// ----------------------------------------------------------------------------
module conveyor_metal_sort_controller_top import cmsc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	output logic    sample_stall,
	input  sample_t sample,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	sample_t sample_s1;
	logic    valid_s1;
	logic    res_valid_q;
	result_t st_q;
	result_t st_nxt;
	logic    advance;

	// result slot is free or being taken this cycle
	assign advance      = !res_valid_q || !result_stall;
	assign sample_stall = valid_s1 && !advance;

	cmsc_step u_step (
		.cur (st_q),
		.smp (sample_s1),
		.nxt (st_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!sample_stall && sample_valid) begin
			sample_s1 <= sample;
		end
	end

	// the result register doubles as the controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			st_q        <= '{phase: PH_START, default: 1'b0};
		end else if (advance) begin
			res_valid_q <= valid_s1;
			if (valid_s1) begin
				st_q <= st_nxt;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign result       = st_q;

endmodule

// File: design/cmsc_checker.sv
// ----------------------------------------------------------------------------
// cmsc_checker
// Port-level checks for the conveyor metal-sort controller.
// ----------------------------------------------------------------------------
module cmsc_checker import cmsc_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    sample_stall,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// hold a stalled result
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// input back-pressure only comes from a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> result_valid && result_stall)
		else $error("sample stalled without a stalled result");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.phase <= PH_ERROR)
		else $error("phase code out of range");

	a_err_safe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.phase == PH_ERROR || result.phase == PH_END)
		|-> !result.drive_right && !result.gate_open && result.start_led)
		else $error("motor or gate active in a stop phase");

	a_transport: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.phase == PH_TRANSPORT
		|-> result.drive_right && result.lamp_green && !result.start_led)
		else $error("transport outputs wrong");

endmodule

bind conveyor_metal_sort_controller_top cmsc_checker u_cmsc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_stall (sample_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

// File: test/conveyor_metal_sort_controller_top_test.sv
// ----------------------------------------------------------------------------
// conveyor_metal_sort_controller_top_test
// Self-checking bench for the conveyor metal-sort controller. A directed
// table walks every sorter phase, the blink cases and the all-ones and
// all-zeros samples. Random sensor sequences follow, mostly shaped to move
// the sorter forward from its current phase. Every result item is checked
// against the typed values of its directed row or else a behavioral model
// of the sorter while both channels idle at random outside a no-gap burst.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module conveyor_metal_sort_controller_top_test import cmsc_pkg::*;;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 5;
	localparam int RANDOM_ITEMS = 1650;
	localparam int HOLD_CYCLES  = 120;
	localparam int HOLD_AT      = 400;
	localparam int BURST_FROM   = 700;
	localparam int BURST_TO     = 900;
	localparam int PAUSE_AT     = 1200;
	localparam int CYCLE_LIMIT  = 250000;

	typedef struct packed {
		sample_t stim;
		logic    typed;
		result_t want;
	} directed_row_t;

	localparam result_t NO_WANT      = '0;
	localparam result_t WANT_STANDBY = '{drive_right: 1'b0, lamp_green: 1'b0, lamp_red: 1'b0,
		lamp_yellow: 1'b0, start_led: 1'b1, gate_open: 1'b0, phase: PH_STANDBY};
	localparam result_t WANT_READY   = '{drive_right: 1'b0, lamp_green: 1'b1, lamp_red: 1'b0,
		lamp_yellow: 1'b0, start_led: 1'b1, gate_open: 1'b0, phase: PH_READY};
	localparam result_t WANT_RED_ON  = '{drive_right: 1'b0, lamp_green: 1'b0, lamp_red: 1'b1,
		lamp_yellow: 1'b0, start_led: 1'b1, gate_open: 1'b0, phase: PH_ERROR};
	localparam result_t WANT_RED_OFF = '{drive_right: 1'b0, lamp_green: 1'b0, lamp_red: 1'b0,
		lamp_yellow: 1'b0, start_led: 1'b1, gate_open: 1'b0, phase: PH_ERROR};

	// Sample bit columns: start_released, item_at_begin, item_at_height, item_at_metal,
	// metal_found, item_at_end, item_passed_slide, seconds_odd
	localparam int DIRECTED_N = 25;
	localparam directed_row_t DIRECTED [DIRECTED_N] = '{
		'{8'b0000_0000, 1'b1, WANT_STANDBY},  // start moves to standby
		'{8'b1000_0000, 1'b0, NO_WANT},       // ready
		'{8'b0100_0000, 1'b0, NO_WANT},       // transport
		'{8'b0001_0000, 1'b0, NO_WANT},       // detect
		'{8'b0000_0000, 1'b0, NO_WANT},       // non-metallic
		'{8'b0000_0101, 1'b0, NO_WANT},       // end reached, green on
		'{8'b0000_0100, 1'b0, NO_WANT},       // end reached, green off
		'{8'b0000_0000, 1'b0, NO_WANT},       // back to ready
		'{8'b0100_0000, 1'b0, NO_WANT},       // transport
		'{8'b0001_1000, 1'b0, NO_WANT},       // detect
		'{8'b0000_1000, 1'b0, NO_WANT},       // metallic
		'{8'b0000_0010, 1'b0, NO_WANT},       // slide reached
		'{8'b0100_0000, 1'b0, NO_WANT},       // next item in transport
		'{8'b0000_0101, 1'b1, WANT_RED_ON},   // end sensor during transport
		'{8'b0000_0000, 1'b1, WANT_RED_OFF},
		'{8'b1000_0000, 1'b1, WANT_STANDBY},
		'{8'b1000_0000, 1'b0, NO_WANT},
		'{8'b0010_0000, 1'b1, WANT_RED_OFF},  // height sensor while ready
		'{8'b1111_1111, 1'b1, WANT_STANDBY},
		'{8'b1111_1111, 1'b1, WANT_READY},
		'{8'b1111_1111, 1'b1, WANT_RED_ON},   // error check wins over release
		'{8'b1000_0000, 1'b0, NO_WANT},
		'{8'b1000_0000, 1'b0, NO_WANT},
		'{8'b1100_0100, 1'b0, NO_WANT},       // begin ignored while end is set
		'{8'b0000_0000, 1'b0, NO_WANT}
	};

	logic    clk;
	logic    arst_n;
	logic    sample_valid;
	logic    sample_stall;
	sample_t sample;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	result_t            expected_results[$];
	logic [PHASE_W-1:0] pred_phase;
	result_t            pred_out;
	int                 error_count;
	int                 samples_sent;
	int                 results_checked;
	int                 cycle_count;
	bit                 burst_mode;
	bit [15:0]          phases_seen;

	conveyor_metal_sort_controller_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #HALF_PERIOD clk = ~clk;

	// One control tick of the sorter: take the transition, then update the sticky outputs.
	function automatic result_t predict_sort(sample_t s);
		logic [PHASE_W-1:0] nxt;
		nxt = pred_phase;
		case (pred_phase)
		PH_START: nxt = PH_STANDBY;
		PH_STANDBY: if (s.start_released) nxt = PH_READY;
		PH_READY: begin
			if (s.start_released) nxt = PH_STANDBY;
			if (s.item_at_begin && !s.item_at_end) nxt = PH_TRANSPORT;
			if (s.item_at_height || s.item_at_metal) nxt = PH_ERROR;
		end
		PH_TRANSPORT: begin
			if (s.item_at_metal) nxt = PH_DETECT;
			if (s.item_at_end) nxt = PH_ERROR;
		end
		PH_DETECT: nxt = s.metal_found ? PH_METAL : PH_NONMETAL;
		PH_NONMETAL: begin
			if (s.item_at_end) nxt = PH_END;
			if (s.item_at_begin || s.item_at_height) nxt = PH_ERROR;
		end
		PH_END: begin
			if (s.start_released) nxt = PH_STANDBY;
			if (!s.item_at_end) nxt = PH_READY;
			if (s.item_at_metal || s.item_at_height) nxt = PH_ERROR;
		end
		PH_METAL: begin
			if (s.item_passed_slide) nxt = PH_SLIDE;
			if (s.item_at_begin || s.item_at_height) nxt = PH_ERROR;
		end
		PH_SLIDE: begin
			if (s.start_released) nxt = PH_STANDBY;
			if (s.item_at_begin) nxt = PH_TRANSPORT;
			if (s.item_at_end || s.item_at_height) nxt = PH_ERROR;
		end
		PH_ERROR: if (s.start_released) nxt = PH_STANDBY;
		default: nxt = PH_START;
		endcase
		pred_phase = nxt;

		// Order of the group: motor, green, red, yellow
		case (nxt)
		PH_START, PH_STANDBY: begin
			{pred_out.drive_right, pred_out.lamp_green, pred_out.lamp_red,
				pred_out.lamp_yellow} = 4'b0000;
			pred_out.start_led = 1'b1;
		end
		PH_READY, PH_SLIDE: begin
			{pred_out.drive_right, pred_out.lamp_green, pred_out.lamp_red,
				pred_out.lamp_yellow} = 4'b0100;
			pred_out.start_led = 1'b1;
		end
		PH_TRANSPORT: begin
			{pred_out.drive_right, pred_out.lamp_green, pred_out.lamp_red,
				pred_out.lamp_yellow} = 4'b1100;
			pred_out.start_led = 1'b0;
		end
		PH_DETECT: begin
			{pred_out.drive_right, pred_out.lamp_green, pred_out.lamp_red,
				pred_out.lamp_yellow} = 4'b0100;
		end
		PH_NONMETAL: begin
			{pred_out.drive_right, pred_out.lamp_green, pred_out.lamp_red,
				pred_out.lamp_yellow} = 4'b1100;
			pred_out.start_led = 1'b0;
			pred_out.gate_open = 1'b1;
		end
		PH_END: begin
			{pred_out.drive_right, pred_out.lamp_red, pred_out.lamp_yellow} = 3'b000;
			pred_out.lamp_green = s.seconds_odd;
			pred_out.start_led  = 1'b1;
			pred_out.gate_open  = 1'b0;
		end
		PH_METAL: begin
			{pred_out.drive_right, pred_out.lamp_green, pred_out.lamp_red,
				pred_out.lamp_yellow} = 4'b1001;
		end
		PH_ERROR: begin
			{pred_out.drive_right, pred_out.lamp_green, pred_out.lamp_yellow} = 3'b000;
			pred_out.lamp_red  = s.seconds_odd;
			pred_out.start_led = 1'b1;
			pred_out.gate_open = 1'b0;
		end
		default: ;
		endcase
		pred_out.phase = nxt;
		return pred_out;
	endfunction

	// Sensor pattern that a real conveyor would show next; a quarter of the time pure noise.
	function automatic sample_t next_sensor_sample(logic [PHASE_W-1:0] ph);
		sample_t s;
		s = '0;
		if ($urandom_range(0, 3) == 0) begin
			s = sample_t'(8'($urandom_range(0, 255)));
			return s;
		end
		s.seconds_odd = 1'($urandom_range(0, 1));
		case (ph)
		PH_STANDBY: s.start_released = 1'($urandom_range(0, 1));
		PH_READY: begin
			s.item_at_begin  = $urandom_range(0, 3) != 0;
			s.start_released = $urandom_range(0, 5) == 0;
		end
		PH_TRANSPORT: begin
			s.item_at_metal = $urandom_range(0, 2) == 0;
			s.item_at_begin = 1'($urandom_range(0, 1));
		end
		PH_DETECT: begin
			s.metal_found   = 1'($urandom_range(0, 1));
			s.item_at_metal = 1'b1;
		end
		PH_NONMETAL: s.item_at_end = 1'($urandom_range(0, 1));
		PH_END: begin
			s.item_at_end    = $urandom_range(0, 2) != 0;
			s.start_released = $urandom_range(0, 4) == 0;
		end
		PH_METAL: s.item_passed_slide = 1'($urandom_range(0, 1));
		PH_SLIDE: begin
			s.item_at_begin  = $urandom_range(0, 2) != 0;
			s.start_released = $urandom_range(0, 4) == 0;
		end
		PH_ERROR: s.start_released = $urandom_range(0, 2) == 0;
		default: ;
		endcase
		return s;
	endfunction

	task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Offer one item after a random gap, none in burst mode, and hold it until the block takes it.
	task automatic send_sample(input sample_t s, input bit typed, input result_t want);
		int gap;
		result_t predicted;
		gap = burst_mode ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		@(posedge clk);
		while (sample_stall !== 1'b0) @(posedge clk);
		predicted = predict_sort(s);
		expected_results.push_back(typed ? want : predicted);
		samples_sent++;
		@(negedge clk);
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample       = '0;
		result_stall = 1'b0;
		pred_phase   = PH_START;
		pred_out     = '0;
		error_count     = 0;
		samples_sent    = 0;
		results_checked = 0;
		cycle_count     = 0;
		burst_mode      = 1'b0;
		phases_seen     = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIRECTED_N; i++)
			send_sample(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].want);

		// Hold off until the directed items have drained.
		sample_valid <= 1'b0;
		wait (expected_results.size() == 0);
		@(negedge clk);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			burst_mode = (i >= BURST_FROM) && (i < BURST_TO);
			if (i == PAUSE_AT) begin
				sample_valid <= 1'b0;
				wait (expected_results.size() == 0);
				@(negedge clk);
			end
			send_sample(next_sensor_sample(pred_phase), 1'b0, NO_WANT);
		end
		burst_mode = 1'b0;
		sample_valid <= 1'b0;

		wait (expected_results.size() == 0);
		repeat (6) @(posedge clk);
		$display("Sent %0d samples, checked %0d results; phases reached (bit per code): %b",
			samples_sent, results_checked, phases_seen[9:0]);
		$display("Run included a %0d-cycle output hold-off, a no-gap burst and a full drain.",
			HOLD_CYCLES);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Receiver: random stall per item (none in burst mode), one long hold-off to fill the block.
	initial begin
		int wait_cycles;
		int taken;
		taken = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (taken == HOLD_AT) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			wait_cycles = burst_mode ? 0 : $urandom_range(0, 9);
			if (wait_cycles > 0) begin
				result_stall <= 1'b1;
				repeat (wait_cycles) @(negedge clk);
			end
			result_stall <= 1'b0;
			@(posedge clk);
			while (result_valid !== 1'b1) @(posedge clk);
			taken++;
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
			if (expected_results.size() == 0) begin
				error_count++;
				$display("%0t: result item with none expected, actual %h", $time, result);
			end else begin
				want = expected_results.pop_front();
				check_field("drive_right", 4'(want.drive_right), 4'(result.drive_right));
				check_field("lamp_green", 4'(want.lamp_green), 4'(result.lamp_green));
				check_field("lamp_red", 4'(want.lamp_red), 4'(result.lamp_red));
				check_field("lamp_yellow", 4'(want.lamp_yellow), 4'(result.lamp_yellow));
				check_field("start_led", 4'(want.start_led), 4'(result.start_led));
				check_field("gate_open", 4'(want.gate_open), 4'(result.gate_open));
				check_field("phase", want.phase, result.phase);
				phases_seen[want.phase] = 1'b1;
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				expected_results.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule
